>>> hdl/lfsta_pkg.sv
// Shared types and constants for the timed lowest-free-slot allocator.
package lfsta_pkg;

   localparam int GUEST_W       = 16;
   localparam int IN_TIME_W     = 32;
   localparam int SLOT_IDX_W    = 6;
   localparam int NUM_SLOTS_DEF = 64;
   localparam int TIME_BITS_DEF = 32;

   typedef struct packed {
      logic start;
      logic commit;
   } scan_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_stat_type;

endpackage

>>> hdl/lfsta_if.sv
// Request and response channel interfaces of the allocator.
interface lfsta_req_if;
   import lfsta_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [GUEST_W-1:0]   guest_id;
   logic [IN_TIME_W-1:0] arrive_time;
   logic [IN_TIME_W-1:0] leave_time;
   modport source (output valid, output guest_id, output arrive_time, output leave_time,
                   input ready);
   modport sink (input valid, input guest_id, input arrive_time, input leave_time,
                 output ready);
endinterface

interface lfsta_rsp_if;
   import lfsta_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic                  target_hit;
   logic                  table_full;
   modport source (output valid, output slot_index, output target_hit, output table_full,
                   input ready);
   modport sink (input valid, input slot_index, input target_hit, input table_full,
                 output ready);
endinterface

>>> hdl/lowest_free_slot_timed_allocator_top.sv
// Top level of the timed lowest-free-slot allocator.
// Each request transaction carries a guest id, an arrival time and a leave time;
// arrival times are expected to be nondecreasing. The block walks the slot table
// one slot per cycle through a single release-time memory read port and one
// comparator: every busy slot whose release time is at or before the arrival time
// is freed, and the lowest free slot is noted. The chosen slot is then marked
// busy until the leave time and one response transaction is produced with its
// index (low 6 bits), a target_hit flag when the guest id equals the target_guest
// register, and table_full with index zero when no slot was free. The req
// ready stays low from acceptance through the slot walk until the grant commits.
// A finished response waits in an output register, and the next request is
// accepted while it waits. No clearing pass follows reset. Write target_guest
// through csr_wr_en/csr_wr_data only while idle.
module lowest_free_slot_timed_allocator_top #(
   parameter int NUM_SLOTS = lfsta_pkg::NUM_SLOTS_DEF,
   parameter int TIME_BITS = lfsta_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   lfsta_req_if.sink                      req,
   lfsta_rsp_if.source                    rsp,
   input  logic                           csr_wr_en,
   input  logic [lfsta_pkg::GUEST_W-1:0]  csr_wr_data
);
   import lfsta_pkg::*;

   localparam int TW    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   scan_cmd_type          cmd;
   scan_stat_type         stat;
   logic [IDX_W-1:0]      chosen;
   logic                  busy_ff;
   logic [GUEST_W-1:0]    guest_ff;
   logic [GUEST_W-1:0]    target_ff;
   logic                  rsp_valid_ff;
   logic [SLOT_IDX_W-1:0] slot_index_ff;
   logic                  target_hit_ff;
   logic                  table_full_ff;
   logic                  req_take;

   // accept a request only while no scan is in flight
   assign req.ready  = !busy_ff;
   assign req_take   = req.valid && req.ready;
   assign cmd.start  = req_take;
   // commit the grant once the response register can take it
   assign cmd.commit = stat.done && (!rsp_valid_ff || rsp.ready);

   lfsta_scan #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .arrive (req.arrive_time[TW-1:0]),
      .leave  (req.leave_time[TW-1:0]),
      .stat   (stat),
      .chosen (chosen)
   );

   // target_guest register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // hold the guest id for the whole scan
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         if (req_take) begin
            busy_ff  <= 1'b1;
            guest_ff <= req.guest_id;
         end else if (cmd.commit) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // response register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff  <= 1'b1;
            slot_index_ff <= stat.found ? SLOT_IDX_W'(chosen) : '0;
            target_hit_ff <= stat.found && (guest_ff == target_ff);
            table_full_ff <= !stat.found;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.slot_index = slot_index_ff;
   assign rsp.target_hit = target_hit_ff;
   assign rsp.table_full = table_full_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req.ready)
      else $error("request accepted while a scan was starting");

   a_commit_when_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.done && busy_ff)
      else $error("grant committed outside a finished scan");

   a_full_payload: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.table_full |-> !rsp.target_hit && (rsp.slot_index == '0))
      else $error("full response carries a grant");

   a_no_start_in_scan: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> busy_ff)
      else $error("scan finished with no request in flight");
`endif

endmodule

>>> hdl/lfsta_scan.sv
// Slot table with a sequential expire-and-search scan over one shared comparator.
module lfsta_scan #(
   parameter int NUM_SLOTS = lfsta_pkg::NUM_SLOTS_DEF,
   parameter int TIME_BITS = lfsta_pkg::TIME_BITS_DEF,
   localparam int TW       = (TIME_BITS < lfsta_pkg::IN_TIME_W) ? TIME_BITS
                                                                : lfsta_pkg::IN_TIME_W,
   localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lfsta_pkg::scan_cmd_type cmd,
   input  logic [TW-1:0]           arrive,
   input  logic [TW-1:0]           leave,
   output lfsta_pkg::scan_stat_type stat,
   output logic [IDX_W-1:0]        chosen
);
   import lfsta_pkg::*;

   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_type;

   state_type          state_ff;
   logic [NUM_SLOTS-1:0] busy_ff;
   logic [TW-1:0]      mem [NUM_SLOTS];
   logic [TW-1:0]      rd_data_ff;
   logic [TW-1:0]      arrive_ff;
   logic [TW-1:0]      leave_ff;
   logic [CNT_W-1:0]   rd_cnt_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               cmp_vld_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   chosen_ff;
   logic               issue_done;
   logic               expire;
   logic               slot_free;
   logic               mem_we;

   assign issue_done = (rd_cnt_ff == CNT_W'(NUM_SLOTS));
   assign expire     = busy_ff[cmp_idx_ff] && (rd_data_ff <= arrive_ff);
   assign slot_free  = !busy_ff[cmp_idx_ff] || expire;
   assign mem_we     = (state_ff == S_COMMIT) && cmd.commit && found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         busy_ff    <= '0;
         rd_cnt_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  arrive_ff  <= arrive;
                  leave_ff   <= leave;
                  rd_cnt_ff  <= '0;
                  cmp_vld_ff <= 1'b0;
                  found_ff   <= 1'b0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               // issue next read, compare the entry read last cycle
               if (!issue_done) begin
                  cmp_idx_ff <= rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_ff  <= rd_cnt_ff + CNT_W'(1);
                  cmp_vld_ff <= 1'b1;
               end else begin
                  cmp_vld_ff <= 1'b0;
               end
               if (cmp_vld_ff) begin
                  if (expire) begin
                     busy_ff[cmp_idx_ff] <= 1'b0;
                  end
                  if (slot_free && !found_ff) begin
                     found_ff  <= 1'b1;
                     chosen_ff <= cmp_idx_ff;
                  end
                  if (issue_done) begin
                     state_ff <= S_COMMIT;
                  end
               end
            end
            S_COMMIT: begin
               if (cmd.commit) begin
                  if (found_ff) begin
                     busy_ff[chosen_ff] <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[chosen_ff] <= leave_ff;
      end
      rd_data_ff <= mem[rd_cnt_ff[IDX_W-1:0]];
   end

   assign stat.done  = (state_ff == S_COMMIT);
   assign stat.found = found_ff;
   assign chosen     = chosen_ff;

endmodule
